FILE: hdl/sdhp_pkg.sv
// sdhp_pkg: shared types, constants and angle helper for the straight drive
// heading controller. No dependencies.

package sdhp_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PROD,
    ST_INTEG,
    ST_PMUL,
    ST_PDIV,
    ST_IDIV,
    ST_IQMUL,
    ST_IRMUL,
    ST_IRDIV,
    ST_DMUL1,
    ST_DMUL2,
    ST_DDIV,
    ST_WMUL,
    ST_WDIV,
    ST_LSET,
    ST_LDIV,
    ST_RDIV
  } state_t;

  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_HEADING   = 3'd1,
    REG_YAW_OFF   = 3'd2,
    REG_GAIN_P    = 3'd3,
    REG_GAIN_I    = 3'd4,
    REG_GAIN_D    = 3'd5,
    REG_FLOOR     = 3'd6,
    REG_CEILING   = 3'd7
  } reg_idx_t;

  localparam logic [11:0] START_SPEED = 12'd1500;
  localparam logic [11:0] STOP_SPEED  = 12'd100;
  localparam logic [11:0] SPEED_DROP  = 12'd13;

  localparam logic [15:0] GAIN_P_RST = 16'd14131;
  localparam logic [15:0] GAIN_I_RST = 16'd41;
  localparam logic [15:0] GAIN_D_RST = 16'd492;

  localparam logic signed [18:0] HALF_TURN = 19'sd18000;
  localparam logic signed [18:0] FULL_TURN = 19'sd36000;

  localparam logic [23:0] DIV_TEN   = 24'd10;
  localparam logic [23:0] DIV_INTEG = 24'd10000000;
  localparam logic [23:0] DIV_IR    = 24'd25;
  localparam logic [19:0] D_SCALE   = 20'd100000;
  localparam logic [19:0] IR_GAIN   = 20'd5632;

  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  function automatic logic signed [15:0] wrap_angle(input logic signed [18:0] x);
    logic signed [18:0] v;
    v = x;
    for (int i = 0; i < 3; i++) begin
      if (v > HALF_TURN) v = v - FULL_TURN;
    end
    for (int i = 0; i < 3; i++) begin
      if (v < -HALF_TURN) v = v + FULL_TURN;
    end
    return v[15:0];
  endfunction

endpackage

FILE: hdl/straight_drive_heading_pid.sv
// straight_drive_heading_pid: straight-line drive controller top level.
// Depends on sdhp_pkg (states, register codes, constants, wrap_angle).
//
// Usage:
//   in_*  : one control tick per beat. in_tuser = new_move, in_tdata holds
//           yaw, encoder counts, side IR readings and elapsed microseconds.
//   out_* : one result beat per tick, left/right speed in out_tdata and
//           move_done in out_tuser.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Timing: a tick that ends or has no move gives its result in the cycle after
//   the input beat. An active tick runs a bit-serial shift-add multiplier and
//   a restoring divider shared over 14 operations, one bit per cycle, before the
//   result is registered. One tick is in flight at a time.
// in_tready is high only while the sequencer is idle and the output register
//   is empty or being drained in the same cycle; a stalled receiver holds the
//   result and blocks the next tick.
// Reset (rst_n low, synchronous) loads register defaults, base speed 150.0,
//   clears integral, previous error, the moving flag and the output register.

module straight_drive_heading_pid #(
  parameter int SPEED_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // yaw[15:0], enc_left[35:16], enc_right[55:36], ir_side_one[67:56],
  // ir_side_three[79:68], elapsed_us[99:80], zero pad[103:100]
  input  logic [103:0]                          in_tdata,
  // new_move
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // left_speed[SPEED_BITS-1:0], right_speed[2*SPEED_BITS-1:SPEED_BITS], zero pad
  output logic [((2*SPEED_BITS+7)/8)*8-1:0]     out_tdata,
  // move_done
  output logic                                  out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [2:0]                            cfg_index,
  input  logic [18:0]                           cfg_data
);

  localparam int OUT_W = ((2*SPEED_BITS+7)/8)*8;

  // configuration
  logic [18:0]        target_r;
  logic signed [15:0] heading_r;
  logic signed [15:0] yaw_off_r;
  logic [15:0]        gain_p_r, gain_i_r, gain_d_r;
  logic [7:0]         floor_r, ceil_r;

  // control state
  sdhp_pkg::state_t   state_r, state_nxt;
  logic [11:0]        base_r, base_nxt;
  logic               moving_r, moving_nxt;
  logic signed [63:0] integ_r, integ_nxt;
  logic signed [16:0] prev_r, prev_nxt;

  // per-tick operands and serial unit
  logic signed [15:0] err_r, err_nxt;
  logic [19:0]        dt_r, dt_nxt;
  logic signed [12:0] ird_r, ird_nxt;
  logic signed [63:0] u_r, u_nxt;
  logic [23:0]        rmd_r, rmd_nxt;
  logic               sgn_r, sgn_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [63:0]        mcand_r, mcand_nxt;
  logic [19:0]        mplier_r, mplier_nxt;
  logic [23:0]        rem_r, rem_nxt;
  logic [23:0]        dvsr_r, dvsr_nxt;

  // output register
  logic                  ov_r, ov_nxt;
  logic [SPEED_BITS-1:0] left_r, left_nxt;
  logic [SPEED_BITS-1:0] right_r, right_nxt;
  logic                  done_r, done_nxt;

  // input fields
  logic [15:0]        in_yaw;
  logic signed [19:0] in_encl, in_encr;
  logic [11:0]        in_ir1, in_ir3;
  logic [19:0]        in_el;
  assign in_yaw  = in_tdata[15:0];
  assign in_encl = in_tdata[35:16];
  assign in_encr = in_tdata[55:36];
  assign in_ir1  = in_tdata[67:56];
  assign in_ir3  = in_tdata[79:68];
  assign in_el   = in_tdata[99:80];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == sdhp_pkg::ST_IDLE) && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'({right_r, left_r});
  assign out_tuser  = done_r;

  function automatic logic [7:0] clamp8(input logic signed [63:0] v,
                                        input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] r;
    if (v < $signed({56'd0, lo}))      r = lo;
    else if (v > $signed({56'd0, hi})) r = hi;
    else                               r = v[7:0];
    return r;
  endfunction

  // tick front end
  logic               mv_eff;
  logic [11:0]        base_eff;
  logic signed [20:0] sum_lr, sum_adj, dist_w, tgt_s;
  logic signed [21:0] diff;
  logic [21:0]        adiff;
  logic               near, end_move;
  logic signed [15:0] yaw_w, err_w;
  logic [19:0]        dt_w;

  always_comb begin
    mv_eff   = moving_r | in_tuser;
    base_eff = in_tuser ? sdhp_pkg::START_SPEED : base_r;
    sum_lr   = {in_encl[19], in_encl} + {in_encr[19], in_encr};
    sum_adj  = sum_lr + {20'd0, sum_lr[20]};
    dist_w   = sum_adj >>> 1;
    tgt_s    = $signed({2'b00, target_r});
    diff     = {dist_w[20], dist_w} - $signed({3'b000, target_r});
    adiff    = diff[21] ? 22'(-diff) : 22'(diff);
    near     = (27'(adiff) * 27'd20) < (27'(target_r) * 27'd7);
    end_move = !mv_eff || (dist_w >= tgt_s) || (base_eff <= sdhp_pkg::STOP_SPEED);
    yaw_w    = sdhp_pkg::wrap_angle($signed({3'b000, in_yaw})
                 - {{3{yaw_off_r[15]}}, yaw_off_r});
    err_w    = sdhp_pkg::wrap_angle({{3{yaw_w[15]}}, yaw_w}
                 - {{3{heading_r[15]}}, heading_r});
    dt_w     = (in_el == 20'd0) ? 20'd1 : in_el;
  end

  // serial unit step
  logic               is_mul, is_div, last;
  logic [63:0]        acc_mul, acc_div, res;
  logic [24:0]        t_div, t_sub;
  logic               ge;
  logic [23:0]        rem_div;
  logic signed [63:0] sres;
  logic [63:0]        isum, padd, mag_i;
  logic               ovf;
  logic signed [17:0] dd;
  logic signed [63:0] s_val, xl, xr;
  logic [63:0]        magl, magr;

  assign is_mul = (state_r == sdhp_pkg::ST_PROD) || (state_r == sdhp_pkg::ST_PMUL) ||
                  (state_r == sdhp_pkg::ST_IQMUL) || (state_r == sdhp_pkg::ST_IRMUL) ||
                  (state_r == sdhp_pkg::ST_DMUL1) || (state_r == sdhp_pkg::ST_DMUL2) ||
                  (state_r == sdhp_pkg::ST_WMUL);
  assign is_div = (state_r == sdhp_pkg::ST_PDIV) || (state_r == sdhp_pkg::ST_IDIV) ||
                  (state_r == sdhp_pkg::ST_IRDIV) || (state_r == sdhp_pkg::ST_DDIV) ||
                  (state_r == sdhp_pkg::ST_WDIV) || (state_r == sdhp_pkg::ST_LDIV) ||
                  (state_r == sdhp_pkg::ST_RDIV);

  always_comb begin
    acc_mul = mplier_r[0] ? acc_r + mcand_r : acc_r;
    t_div   = {rem_r, acc_r[63]};
    ge      = t_div >= {1'b0, dvsr_r};
    t_sub   = t_div - {1'b0, dvsr_r};
    rem_div = ge ? t_sub[23:0] : t_div[23:0];
    acc_div = {acc_r[62:0], ge};
    res     = is_div ? acc_div : acc_mul;
    sres    = sgn_r ? -$signed(res) : $signed(res);
    last    = (is_mul || is_div) && (cnt_r == 7'd1);
    padd    = acc_r ^ {64{sgn_r}};
    isum    = integ_r + padd + 64'(sgn_r);
    ovf     = (integ_r[63] == sgn_r) && (isum[63] != sgn_r);
    mag_i   = integ_r[63] ? 64'(-integ_r) : 64'(integ_r);
    dd      = {{2{err_r[15]}}, err_r} - {prev_r[16], prev_r};
    s_val   = $signed({40'd0, base_r, 12'd0});
    xl      = s_val - u_r;
    xr      = s_val + u_r;
    magl    = xl[63] ? 64'(-xl) : 64'(xl);
    magr    = xr[63] ? 64'(-xr) : 64'(xr);
  end

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    moving_nxt = moving_r;
    integ_nxt  = integ_r;
    prev_nxt   = prev_r;
    err_nxt    = err_r;
    dt_nxt     = dt_r;
    ird_nxt    = ird_r;
    u_nxt      = u_r;
    rmd_nxt    = rmd_r;
    sgn_nxt    = sgn_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    dvsr_nxt   = dvsr_r;
    ov_nxt     = ov_r && !out_tready;
    left_nxt   = left_r;
    right_nxt  = right_r;
    done_nxt   = done_r;

    if (is_mul) begin
      acc_nxt    = acc_mul;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 7'd1;
    end
    if (is_div) begin
      acc_nxt = acc_div;
      rem_nxt = rem_div;
      cnt_nxt = cnt_r - 7'd1;
    end

    unique case (state_r)
      sdhp_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser) base_nxt = sdhp_pkg::START_SPEED;
          if (end_move) begin
            moving_nxt = 1'b0;
            left_nxt   = '0;
            right_nxt  = '0;
            done_nxt   = 1'b1;
            ov_nxt     = 1'b1;
          end else begin
            moving_nxt = 1'b1;
            base_nxt   = near ? base_eff - sdhp_pkg::SPEED_DROP : base_eff;
            err_nxt    = err_w;
            dt_nxt     = dt_w;
            ird_nxt    = $signed({1'b0, in_ir1}) - $signed({1'b0, in_ir3});
            sgn_nxt    = err_w[15];
            mcand_nxt  = 64'(err_w[15] ? 16'(-err_w) : 16'(err_w));
            mplier_nxt = dt_w;
            acc_nxt    = '0;
            cnt_nxt    = 7'd20;
            state_nxt  = sdhp_pkg::ST_PROD;
          end
        end
      end
      sdhp_pkg::ST_PROD: begin
        if (last) state_nxt = sdhp_pkg::ST_INTEG;
      end
      sdhp_pkg::ST_INTEG: begin
        if (ovf) integ_nxt = sgn_r ? $signed(sdhp_pkg::INT64_MIN)
                                   : $signed(sdhp_pkg::INT64_MAX);
        else     integ_nxt = $signed(isum);
        mcand_nxt  = 64'(err_r[15] ? 16'(-err_r) : 16'(err_r));
        mplier_nxt = 20'(gain_p_r);
        acc_nxt    = '0;
        cnt_nxt    = 7'd16;
        state_nxt  = sdhp_pkg::ST_PMUL;
      end
      sdhp_pkg::ST_PMUL: begin
        if (last) begin
          acc_nxt   = res << 32;
          rem_nxt   = '0;
          dvsr_nxt  = sdhp_pkg::DIV_TEN;
          cnt_nxt   = 7'd32;
          state_nxt = sdhp_pkg::ST_PDIV;
        end
      end
      sdhp_pkg::ST_PDIV: begin
        if (last) begin
          u_nxt     = sres;
          sgn_nxt   = integ_r[63];
          acc_nxt   = mag_i;
          rem_nxt   = '0;
          dvsr_nxt  = sdhp_pkg::DIV_INTEG;
          cnt_nxt   = 7'd64;
          state_nxt = sdhp_pkg::ST_IDIV;
        end
      end
      sdhp_pkg::ST_IDIV: begin
        if (last) begin
          rmd_nxt    = rem_div;
          mcand_nxt  = res;
          mplier_nxt = 20'(gain_i_r);
          acc_nxt    = '0;
          cnt_nxt    = 7'd16;
          state_nxt  = sdhp_pkg::ST_IQMUL;
        end
      end
      sdhp_pkg::ST_IQMUL: begin
        if (last) begin
          u_nxt      = u_r + sres;
          mcand_nxt  = 64'(rmd_r);
          mplier_nxt = 20'(gain_i_r);
          acc_nxt    = '0;
          cnt_nxt    = 7'd16;
          state_nxt  = sdhp_pkg::ST_IRMUL;
        end
      end
      sdhp_pkg::ST_IRMUL: begin
        if (last) begin
          acc_nxt   = res << 24;
          rem_nxt   = '0;
          dvsr_nxt  = sdhp_pkg::DIV_INTEG;
          cnt_nxt   = 7'd40;
          state_nxt = sdhp_pkg::ST_IRDIV;
        end
      end
      sdhp_pkg::ST_IRDIV: begin
        if (last) begin
          u_nxt      = u_r + sres;
          prev_nxt   = 17'(err_r);
          sgn_nxt    = dd[17];
          mcand_nxt  = 64'(dd[17] ? 18'(-dd) : 18'(dd));
          mplier_nxt = 20'(gain_d_r);
          acc_nxt    = '0;
          cnt_nxt    = 7'd16;
          state_nxt  = sdhp_pkg::ST_DMUL1;
        end
      end
      sdhp_pkg::ST_DMUL1: begin
        if (last) begin
          mcand_nxt  = res;
          mplier_nxt = sdhp_pkg::D_SCALE;
          acc_nxt    = '0;
          cnt_nxt    = 7'd17;
          state_nxt  = sdhp_pkg::ST_DMUL2;
        end
      end
      sdhp_pkg::ST_DMUL2: begin
        if (last) begin
          acc_nxt   = res << 14;
          rem_nxt   = '0;
          dvsr_nxt  = 24'(dt_r);
          cnt_nxt   = 7'd50;
          state_nxt = sdhp_pkg::ST_DDIV;
        end
      end
      sdhp_pkg::ST_DDIV: begin
        if (last) begin
          u_nxt      = u_r + sres;
          sgn_nxt    = ird_r[12];
          mcand_nxt  = 64'(ird_r[12] ? 13'(-ird_r) : 13'(ird_r));
          mplier_nxt = sdhp_pkg::IR_GAIN;
          acc_nxt    = '0;
          cnt_nxt    = 7'd13;
          state_nxt  = sdhp_pkg::ST_WMUL;
        end
      end
      sdhp_pkg::ST_WMUL: begin
        if (last) begin
          acc_nxt   = res << 39;
          rem_nxt   = '0;
          dvsr_nxt  = sdhp_pkg::DIV_IR;
          cnt_nxt   = 7'd25;
          state_nxt = sdhp_pkg::ST_WDIV;
        end
      end
      sdhp_pkg::ST_WDIV: begin
        if (last) begin
          u_nxt     = u_r + sres;
          state_nxt = sdhp_pkg::ST_LSET;
        end
      end
      sdhp_pkg::ST_LSET: begin
        sgn_nxt   = xl[63];
        acc_nxt   = {magl[59:12], 16'd0};
        rem_nxt   = '0;
        dvsr_nxt  = sdhp_pkg::DIV_TEN;
        cnt_nxt   = 7'd48;
        state_nxt = sdhp_pkg::ST_LDIV;
      end
      sdhp_pkg::ST_LDIV: begin
        if (last) begin
          left_nxt  = SPEED_BITS'(clamp8(sres, floor_r, ceil_r));
          sgn_nxt   = xr[63];
          acc_nxt   = {magr[59:12], 16'd0};
          rem_nxt   = '0;
          cnt_nxt   = 7'd48;
          state_nxt = sdhp_pkg::ST_RDIV;
        end
      end
      sdhp_pkg::ST_RDIV: begin
        if (last) begin
          right_nxt = SPEED_BITS'(clamp8(sres, floor_r, ceil_r));
          done_nxt  = 1'b0;
          ov_nxt    = 1'b1;
          state_nxt = sdhp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sdhp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sdhp_pkg::ST_IDLE;
      base_r   <= sdhp_pkg::START_SPEED;
      moving_r <= 1'b0;
      integ_r  <= '0;
      prev_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      moving_r <= moving_nxt;
      integ_r  <= integ_nxt;
      prev_r   <= prev_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r    <= err_nxt;
    dt_r     <= dt_nxt;
    ird_r    <= ird_nxt;
    u_r      <= u_nxt;
    rmd_r    <= rmd_nxt;
    sgn_r    <= sgn_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    dvsr_r   <= dvsr_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    done_r   <= done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      heading_r <= '0;
      yaw_off_r <= '0;
      gain_p_r  <= sdhp_pkg::GAIN_P_RST;
      gain_i_r  <= sdhp_pkg::GAIN_I_RST;
      gain_d_r  <= sdhp_pkg::GAIN_D_RST;
      floor_r   <= '0;
      ceil_r    <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sdhp_pkg::reg_idx_t'(cfg_index))
        sdhp_pkg::REG_TARGET:  target_r  <= cfg_data;
        sdhp_pkg::REG_HEADING: heading_r <= cfg_data[15:0];
        sdhp_pkg::REG_YAW_OFF: yaw_off_r <= cfg_data[15:0];
        sdhp_pkg::REG_GAIN_P:  gain_p_r  <= cfg_data[15:0];
        sdhp_pkg::REG_GAIN_I:  gain_i_r  <= cfg_data[15:0];
        sdhp_pkg::REG_GAIN_D:  gain_d_r  <= cfg_data[15:0];
        sdhp_pkg::REG_FLOOR:   floor_r   <= cfg_data[7:0];
        sdhp_pkg::REG_CEILING: ceil_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == sdhp_pkg::ST_IDLE)
    else $error("input ready outside idle");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("stopped beat carries nonzero speed");

  a_busy_moving: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sdhp_pkg::ST_IDLE |-> moving_r)
    else $error("sequencer busy without active move");

  a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sdhp_pkg::ST_IDLE |-> !out_tvalid)
    else $error("result pending while tick in flight");

  a_dvsr_nz: assert property (@(posedge clk) disable iff (!rst_n)
    is_div |-> dvsr_r != 24'd0)
    else $error("divide by zero in serial divider");

endmodule

FILE: bench/straight_drive_heading_pid_tb.sv
// straight_drive_heading_pid_tb: self-checking bench for the straight drive heading
// controller; drives ticks, config writes and result backpressure, checks vs local predictor.
// Depends on sdhp_pkg and straight_drive_heading_pid.

module straight_drive_heading_pid_tb;

  typedef struct {
    bit               new_move;
    logic [15:0]      yaw;
    logic signed [19:0] enc_l;
    logic signed [19:0] enc_r;
    logic [11:0]      ir1;
    logic [11:0]      ir3;
    logic [19:0]      dt;
  } tick_t;

  typedef struct {
    logic [7:0] left;
    logic [7:0] right;
    bit         done;
  } speeds_t;

  typedef struct {
    tick_t   t;
    bit      typed;
    speeds_t want;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [103:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [15:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [18:0] cfg_data;

  straight_drive_heading_pid dut (.*);

  // controller copy
  logic [18:0] target_ticks;
  logic signed [15:0] heading_tgt, yaw_off;
  logic [15:0] kp, ki, kd;
  logic [7:0] spd_floor, spd_ceil;
  longint base_tenths, err_integ, prev_err;
  bit moving;

  speeds_t speeds_q[$];
  int errors = 0;
  int snd_idle = 0, rcv_idle = 0, hold_cycles = 0;
  int beats_in = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint wrap_cdeg(longint x);
    while (x > 18000) x -= 36000;
    while (x < -18000) x += 36000;
    return x;
  endfunction

  function automatic logic [7:0] clamp_spd(longint v);
    if (v < longint'(spd_floor)) v = longint'(spd_floor);
    else if (v > longint'(spd_ceil)) v = longint'(spd_ceil);
    return v[7:0];
  endfunction

  function automatic speeds_t steer(tick_t t);
    speeds_t r;
    longint mean_ticks, tgt, diff, yaw, err, dt, prod, u, w, s, q, rm;
    longint max64, min64;
    max64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    min64 = 64'sh8000_0000_0000_0000;
    if (t.new_move) begin
      moving = 1;
      base_tenths = 1500;
    end
    mean_ticks = (longint'(t.enc_l) + longint'(t.enc_r)) / 2;
    tgt = longint'(target_ticks);
    if (!moving || mean_ticks >= tgt || base_tenths <= 100) begin
      moving = 0;
      r = '{8'd0, 8'd0, 1'b1};
      return r;
    end
    diff = mean_ticks - tgt;
    if (diff < 0) diff = -diff;
    if (20 * diff < 7 * tgt) base_tenths -= 13;
    yaw = wrap_cdeg(longint'(t.yaw) - longint'(yaw_off));
    err = wrap_cdeg(yaw - longint'(heading_tgt));
    dt = (t.dt == 0) ? 1 : longint'(t.dt);
    prod = err * dt;
    if (prod > 0 && err_integ > max64 - prod) err_integ = max64;
    else if (prod < 0 && err_integ < min64 - prod) err_integ = min64;
    else err_integ += prod;
    u = (longint'(kp) * err) / 10;
    q = err_integ / 10000000;
    rm = err_integ % 10000000;
    u += longint'(ki) * q + (longint'(ki) * rm) / 10000000;
    u += (longint'(kd) * (err - prev_err) * 100000) / dt;
    prev_err = err;
    w = ((longint'(t.ir1) - longint'(t.ir3)) * 5632) / 25;
    s = base_tenths * 4096;
    r.left = clamp_spd((s - u - w) / 40960);
    r.right = clamp_spd((s + u + w) / 40960);
    r.done = 0;
    return r;
  endfunction

  task automatic write_reg(sdhp_pkg::reg_idx_t idx, logic [18:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      sdhp_pkg::REG_TARGET:  target_ticks = val;
      sdhp_pkg::REG_HEADING: heading_tgt = val[15:0];
      sdhp_pkg::REG_YAW_OFF: yaw_off = val[15:0];
      sdhp_pkg::REG_GAIN_P:  kp = val[15:0];
      sdhp_pkg::REG_GAIN_I:  ki = val[15:0];
      sdhp_pkg::REG_GAIN_D:  kd = val[15:0];
      sdhp_pkg::REG_FLOOR:   spd_floor = val[7:0];
      default:               spd_ceil = val[7:0];
    endcase
  endtask

  task automatic drain;
    while (speeds_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_tick(tick_t t, bit typed, speeds_t want);
    speeds_t p;
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= t.new_move;
    in_tdata <= {4'd0, t.dt, t.ir3, t.ir1, t.enc_r, t.enc_l, t.yaw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = steer(t);
    speeds_q.push_back(typed ? want : p);
    beats_in++;
    if (beats_in == 100 || beats_in == 700) hold_cycles = 4000;
  endtask

  always @(posedge clk) begin
    speeds_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (speeds_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = speeds_q.pop_front();
        if (out_tdata[7:0] !== e.left) begin
          $error("left_speed exp %0d got %0d", e.left, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== e.right) begin
          $error("right_speed exp %0d got %0d", e.right, out_tdata[15:8]);
          errors++;
        end
        if (out_tuser !== e.done) begin
          $error("move_done exp %0d got %0d", e.done, out_tuser);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  function automatic tick_t rand_tick();
    tick_t t;
    t.new_move = 1'($urandom_range(1));
    t.yaw = 16'($urandom);
    t.enc_l = 20'($urandom);
    t.enc_r = 20'($urandom);
    t.ir1 = 12'($urandom);
    t.ir3 = 12'($urandom);
    t.dt = 20'($urandom);
    return t;
  endfunction

  task automatic rand_config(int kind);
    case (kind)
      0: begin
        write_reg(sdhp_pkg::REG_TARGET, 19'h7FFFF);
        write_reg(sdhp_pkg::REG_HEADING, 19'(-18000));
        write_reg(sdhp_pkg::REG_YAW_OFF, 19'd18000);
        write_reg(sdhp_pkg::REG_GAIN_P, 19'hFFFF);
        write_reg(sdhp_pkg::REG_GAIN_I, 19'hFFFF);
        write_reg(sdhp_pkg::REG_GAIN_D, 19'hFFFF);
        write_reg(sdhp_pkg::REG_FLOOR, 19'd200);
        write_reg(sdhp_pkg::REG_CEILING, 19'd40);
      end
      1: begin
        write_reg(sdhp_pkg::REG_GAIN_P, 19'd0);
        write_reg(sdhp_pkg::REG_GAIN_I, 19'd0);
        write_reg(sdhp_pkg::REG_GAIN_D, 19'd0);
        write_reg(sdhp_pkg::REG_FLOOR, 19'd0);
        write_reg(sdhp_pkg::REG_CEILING, 19'd255);
        write_reg(sdhp_pkg::REG_HEADING, 19'd18000);
        write_reg(sdhp_pkg::REG_YAW_OFF, 19'(-18000));
      end
      default: begin
        write_reg(sdhp_pkg::REG_TARGET, 19'($urandom_range(3000)));
        write_reg(sdhp_pkg::REG_HEADING, ($urandom_range(9) == 0) ? 19'($urandom)
                                : 19'($urandom_range(36000) - 18000));
        write_reg(sdhp_pkg::REG_YAW_OFF, ($urandom_range(9) == 0) ? 19'($urandom)
                                : 19'($urandom_range(36000) - 18000));
        write_reg(sdhp_pkg::REG_GAIN_P, 19'($urandom_range(30000)));
        write_reg(sdhp_pkg::REG_GAIN_I, 19'($urandom_range(2000)));
        write_reg(sdhp_pkg::REG_GAIN_D, 19'($urandom_range(4000)));
        write_reg(sdhp_pkg::REG_FLOOR, 19'($urandom_range(80)));
        write_reg(sdhp_pkg::REG_CEILING, 19'($urandom_range(120, 255)));
      end
    endcase
  endtask

  row_t dir_rows[] = '{
    '{'{0, 16'd0, 20'sd0, 20'sd0, 12'd0, 12'd0, 20'd1}, 1, '{8'd0, 8'd0, 1'b1}},
    '{'{1, 16'd0, 20'sd0, 20'sd0, 12'd0, 12'd0, 20'd1}, 1, '{8'd0, 8'd0, 1'b1}},
    '{'{1, 16'd0, -20'sd524288, -20'sd524288, 12'd0, 12'd0, 20'd1}, 0, '{0, 0, 0}},
    '{'{0, 16'd35999, -20'sd9, -20'sd9, 12'd4095, 12'd0, 20'hFFFFF}, 0, '{0, 0, 0}},
    '{'{0, 16'd18000, -20'sd9, -20'sd9, 12'd0, 12'd4095, 20'd0}, 0, '{0, 0, 0}},
    '{'{0, 16'hFFFF, -20'sd100, -20'sd2, 12'd7, 12'd9, 20'd1000}, 0, '{0, 0, 0}},
    '{'{0, 16'd9000, -20'sd1, 20'sd0, 12'd0, 12'd0, 20'd1}, 1, '{8'd0, 8'd0, 1'b1}},
    '{'{0, 16'd0, 20'sd524287, 20'sd524287, 12'd0, 12'd0, 20'd1}, 1, '{8'd0, 8'd0, 1'b1}},
    '{'{1, 16'd27000, -20'sd3, -20'sd4, 12'd100, 12'd50, 20'd500}, 0, '{0, 0, 0}},
    '{'{0, 16'd1, -20'sd40, -20'sd40, 12'd4095, 12'd4095, 20'd1}, 0, '{0, 0, 0}},
    '{'{0, 16'd0, 20'sd524287, -20'sd524288, 12'd0, 12'd0, 20'd1}, 1, '{8'd0, 8'd0, 1'b1}}
  };

  initial begin
    tick_t t;
    speeds_t none;
    int sent, tgt, pos, len, step;
    none = '{0, 0, 0};
    rst_n = 0;
    in_tvalid = 0; in_tuser = 0; in_tdata = '0;
    out_tready = 0;
    cfg_valid = 0; cfg_index = sdhp_pkg::REG_TARGET; cfg_data = '0;
    target_ticks = 0; heading_tgt = 0; yaw_off = 0;
    kp = 14131; ki = 41; kd = 492; spd_floor = 0; spd_ceil = 255;
    base_tenths = 1500; err_integ = 0; prev_err = 0; moving = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    snd_idle = 17; rcv_idle = 53;
    foreach (dir_rows[i]) send_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
    sent = dir_rows.size();
    for (int ph = 0; sent < 950; ph++) begin
      in_tvalid <= 0;
      drain();
      rand_config(ph % 5);
      for (int k = 0; k < 120 && sent < 950; ) begin
        if (sent > 320 && sent <= 640) begin snd_idle = 53; rcv_idle = 17; end
        else if (sent > 640) begin snd_idle = 0; rcv_idle = 0; end
        if ($urandom_range(9) == 0) begin
          send_tick(rand_tick(), 0, none);
          k++; sent++;
        end else begin
          // well-formed move toward the target, may linger near it
          tgt = target_ticks;
          len = $urandom_range(3, 40);
          step = (tgt / len) + 1;
          pos = 0;
          for (int j = 0; j < len + $urandom_range(0, 130) && sent < 950; j++) begin
            t = rand_tick();
            t.new_move = (j == 0);
            t.yaw = 16'($urandom_range(35999));
            t.dt = 20'($urandom_range(1, 20000));
            t.ir1 = 12'($urandom_range(1500, 2500));
            t.ir3 = 12'($urandom_range(1500, 2500));
            if (pos + step < tgt || $urandom_range(3) == 0) pos += $urandom_range(step);
            t.enc_l = 20'(pos + $urandom_range(4) - 2);
            t.enc_r = 20'(pos + $urandom_range(4) - 2);
            send_tick(t, 0, none);
            k++; sent++;
          end
        end
      end
    end
    in_tvalid <= 0;
    drain();
    repeat (500) @(posedge clk);
    if (errors == 0 && speeds_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
